// ===== hdl/iso2j_pkg.sv =====
`timescale 1ns / 1ps

package iso2j_pkg;

    localparam int GRID_SIDE_DEF = 94;
    localparam int SLOT_W        = 14;
    localparam int CP_W          = 16;
    localparam int ERR_W         = 3;

    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_PAREN  = 8'h28;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_B      = 8'h42;
    localparam logic [7:0] BYTE_J      = 8'h4A;
    localparam logic [7:0] BYTE_AT     = 8'h40;
    localparam logic [7:0] BYTE_SO     = 8'h0E;
    localparam logic [7:0] BYTE_SI     = 8'h0F;
    localparam logic [7:0] GRID_LO     = 8'd33;
    localparam logic [7:0] GRID_HI     = 8'h7E;
    localparam logic [CP_W-1:0] REPLACEMENT = 16'hFFFD;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_EOS   = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_ESCAPE   = 3'd1,
        ERR_SHIFT    = 3'd2,
        ERR_GRID     = 3'd3,
        ERR_UNMAPPED = 3'd4,
        ERR_CUT      = 3'd5,
        ERR_END      = 3'd6,
        ERR_HIGH     = 3'd7
    } t_err;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_ONE  = 2'd1,
        ESC_TWO  = 2'd2
    } t_esc;

    typedef struct packed {
        logic              char_valid;
        logic [CP_W-1:0]   code_point;
        t_err              error_code;
        logic [SLOT_W-1:0] grid_slot;
    } t_result;

endpackage

// ===== hdl/iso2j_in_if.sv =====
`timescale 1ns / 1ps

interface iso2j_in_if import iso2j_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [7:0]         data_byte;
    logic [SLOT_W-1:0]  grid_index;
    logic [CP_W-1:0]    grid_value;

    modport source (output valid, opcode, data_byte, grid_index, grid_value, input ready);
    modport sink   (input valid, opcode, data_byte, grid_index, grid_value, output ready);
endinterface

// ===== hdl/iso2j_out_if.sv =====
`timescale 1ns / 1ps

interface iso2j_out_if import iso2j_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               char_valid;
    logic [CP_W-1:0]    code_point;
    logic [ERR_W-1:0]   error_code;
    logic [SLOT_W-1:0]  grid_slot;

    modport source (output valid, char_valid, code_point, error_code, grid_slot, input ready);
    modport sink   (input valid, char_valid, code_point, error_code, grid_slot, output ready);
endinterface

// ===== hdl/iso2022jp_decoder.sv =====
`timescale 1ns / 1ps

// iso-2022-jp byte decoder
// input channel i_in: one beat per item; opcode selects a data byte, an
// end-of-stream marker or a write of one grid table cell (index, code point)
// output channel o_out: zero or one beat per input item, in input order,
// carrying char_valid, code_point, error_code and grid_slot
// throughput: one input beat per cycle while i_in.ready is high; the grid
// memory has a single read port that is read once per trail byte
// path: a result beat passes through the read stage register, where the
// synchronous grid read lands, and then through the output queue before it
// shows on o_out
// reset: decoder returns to ascii mode with no escape or lead byte pending,
// and the output queue empties; the grid memory keeps its contents and is not
// defined until loaded, so every cell must be written before a jis pair
// reaches it
// stall: results collect in a three-entry queue; i_in.ready falls once the
// queue and the read stage hold three beats, and rises again as o_out drains
// end of stream reports any unfinished state and returns to reset state
module iso2022jp_decoder import iso2j_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iso2j_in_if.sink    i_in,
    iso2j_out_if.source o_out
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(GRID_SIDE);
    localparam int QDEPTH = 3;
    // last byte value that lands on the grid
    localparam logic [7:0] GRID_TOP = 8'(int'(GRID_LO) + GRID_SIDE - 1);

    // decoder state
    logic              r_jis_mode,     n_jis_mode;
    t_esc              r_esc_phase,    n_esc_phase;
    logic [7:0]        r_esc_first,    n_esc_first;
    logic              r_lead_pending, n_lead_pending;
    logic [7:0]        r_lead_row,     n_lead_row;

    // grid memory
    logic [CP_W-1:0]   r_grid [CELLS];
    logic [CP_W-1:0]   r_rdata;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [ADDR_W-1:0] w_mem_raddr;

    // read stage
    logic              r_s1_v;
    logic              r_s1_has;
    logic              r_s1_lookup;
    logic [SLOT_W-1:0] r_s1_slot;
    t_result           r_s1_res;
    logic              w_has;
    logic              w_lookup;
    t_result           w_res;
    t_result           w_s1_out;

    // output queue
    t_result           r_q [QDEPTH];
    logic [1:0]        r_wr_ptr;
    logic [1:0]        r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;
    logic              w_accept;
    logic [2:0]        w_inflight;

    logic [ROW_W-1:0]  w_row;
    logic [ROW_W-1:0]  w_col;
    logic [SLOT_W-1:0] w_slot;
    logic              w_lead_ok;
    logic              w_trail_ok;
    t_opcode           w_op;
    logic [7:0]        w_b;

    assign w_op = t_opcode'(i_in.opcode);
    assign w_b  = i_in.data_byte;

    // queue plus read stage may hold at most three beats
    assign w_inflight = {1'b0, r_cnt} + {2'b00, r_s1_v};
    assign i_in.ready = (w_inflight < 3'(QDEPTH));
    assign w_accept   = i_in.valid && i_in.ready;

    // grid address of the pair: (lead - 33) * side + (trail - 33)
    assign w_row      = ROW_W'(r_lead_row - GRID_LO);
    assign w_col      = ROW_W'(w_b - GRID_LO);
    assign w_slot     = SLOT_W'(SLOT_W'(w_row) * SLOT_W'(GRID_SIDE)) + SLOT_W'(w_col);
    assign w_lead_ok  = (r_lead_row >= GRID_LO) && (r_lead_row <= GRID_TOP);
    assign w_trail_ok = (w_b >= GRID_LO) && (w_b <= GRID_TOP);

    // next decoder state and result of the accepted beat
    always_comb begin
        n_jis_mode     = r_jis_mode;
        n_esc_phase    = r_esc_phase;
        n_esc_first    = r_esc_first;
        n_lead_pending = r_lead_pending;
        n_lead_row     = r_lead_row;
        w_has          = 1'b0;
        w_lookup       = 1'b0;
        w_res          = '{char_valid: 1'b0, code_point: '0, error_code: ERR_OK, grid_slot: '0};
        w_mem_we       = 1'b0;
        w_mem_re       = 1'b0;
        if (w_accept) begin
            unique case (w_op)
                OP_DATA: begin
                    priority if (r_esc_phase == ESC_ONE) begin
                        n_esc_first = w_b;
                        n_esc_phase = ESC_TWO;
                    end else if (r_esc_phase == ESC_TWO) begin
                        n_esc_phase = ESC_NONE;
                        if (r_esc_first == BYTE_PAREN && (w_b == BYTE_B || w_b == BYTE_J)) begin
                            n_jis_mode = 1'b0;
                        end else if (r_esc_first == BYTE_DOLLAR &&
                                     (w_b == BYTE_AT || w_b == BYTE_B)) begin
                            n_jis_mode = 1'b1;
                        end else begin
                            w_has            = 1'b1;
                            w_res.error_code = ERR_ESCAPE;
                        end
                    end else if (w_b == BYTE_ESC) begin
                        // escape cuts a pending lead byte short
                        n_esc_phase = ESC_ONE;
                        if (r_lead_pending) begin
                            n_lead_pending   = 1'b0;
                            w_has            = 1'b1;
                            w_res.char_valid = 1'b1;
                            w_res.code_point = REPLACEMENT;
                            w_res.error_code = ERR_CUT;
                        end
                    end else if (!r_jis_mode) begin
                        w_has            = 1'b1;
                        w_res.char_valid = 1'b1;
                        priority if (w_b == BYTE_SO || w_b == BYTE_SI) begin
                            w_res.code_point = REPLACEMENT;
                            w_res.error_code = ERR_SHIFT;
                        end else if (w_b[7]) begin
                            w_res.code_point = REPLACEMENT;
                            w_res.error_code = ERR_HIGH;
                        end else begin
                            w_res.code_point = CP_W'(w_b);
                        end
                    end else if (!r_lead_pending) begin
                        n_lead_row     = w_b;
                        n_lead_pending = 1'b1;
                    end else begin
                        n_lead_pending   = 1'b0;
                        w_has            = 1'b1;
                        w_res.char_valid = 1'b1;
                        if (!w_lead_ok || !w_trail_ok) begin
                            w_res.code_point = REPLACEMENT;
                            w_res.error_code = ERR_GRID;
                        end else begin
                            // code point comes from the grid read next cycle
                            w_lookup = 1'b1;
                            w_mem_re = 1'b1;
                        end
                    end
                end
                OP_EOS: begin
                    if (r_lead_pending) begin
                        w_has            = 1'b1;
                        w_res.char_valid = 1'b1;
                        w_res.code_point = REPLACEMENT;
                        w_res.error_code = ERR_END;
                    end else if (r_esc_phase != ESC_NONE || r_jis_mode) begin
                        w_has            = 1'b1;
                        w_res.error_code = ERR_END;
                    end
                    n_jis_mode     = 1'b0;
                    n_esc_phase    = ESC_NONE;
                    n_esc_first    = '0;
                    n_lead_pending = 1'b0;
                    n_lead_row     = '0;
                end
                OP_WRITE: begin
                    // indexes past the grid are dropped
                    w_mem_we = (i_in.grid_index < SLOT_W'(CELLS));
                end
                OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign w_mem_waddr = ADDR_W'(i_in.grid_index);
    assign w_mem_raddr = ADDR_W'(w_slot);

    // decoder state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jis_mode     <= 1'b0;
            r_esc_phase    <= ESC_NONE;
            r_esc_first    <= '0;
            r_lead_pending <= 1'b0;
            r_lead_row     <= '0;
        end else begin
            r_jis_mode     <= n_jis_mode;
            r_esc_phase    <= n_esc_phase;
            r_esc_first    <= n_esc_first;
            r_lead_pending <= n_lead_pending;
            r_lead_row     <= n_lead_row;
        end
    end

    // grid memory, one write and one registered read port; a write is
    // always a beat ahead of any read that could see it
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_grid[w_mem_waddr] <= i_in.grid_value;
        end
        if (w_mem_re) begin
            r_rdata <= r_grid[w_mem_raddr];
        end
    end

    // read stage: control under reset, payload free running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s1_has    <= 1'b0;
            r_s1_lookup <= 1'b0;
        end else begin
            r_s1_v      <= w_accept;
            r_s1_has    <= w_has;
            r_s1_lookup <= w_lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_res  <= w_res;
        r_s1_slot <= w_slot;
    end

    // merge the grid value into the result
    always_comb begin
        w_s1_out = r_s1_res;
        if (r_s1_lookup) begin
            if (r_rdata == REPLACEMENT) begin
                w_s1_out.code_point = REPLACEMENT;
                w_s1_out.error_code = ERR_UNMAPPED;
                w_s1_out.grid_slot  = r_s1_slot;
            end else begin
                w_s1_out.code_point = r_rdata;
            end
        end
    end

    // output queue
    assign w_push = r_s1_v && r_s1_has;
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_s1_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == 2'(QDEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'(QDEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.char_valid = r_q[r_rd_ptr].char_valid;
    assign o_out.code_point = r_q[r_rd_ptr].code_point;
    assign o_out.error_code = r_q[r_rd_ptr].error_code;
    assign o_out.grid_slot  = r_q[r_rd_ptr].grid_slot;

`ifndef SYNTHESIS
    // queue plus read stage never overflow
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_inflight <= 3'(QDEPTH)))
        else $error("output queue overflow");

    // a lead byte is only held in jis mode
    a_lead_in_jis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead_pending |-> r_jis_mode)
        else $error("lead byte pending outside jis mode");

    // a grid lookup follows a jis trail byte taken in the previous cycle
    a_lookup_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_lookup |-> (r_s1_v && r_s1_has && $past(r_jis_mode) && $past(r_lead_pending)))
        else $error("grid lookup without a trail byte");

    // a beat without a character always carries an error
    a_flag_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.char_valid) |-> (o_out.error_code != ERR_OK))
        else $error("empty beat without error");
`endif

endmodule
